@@ hw/rtl/csm_pkg.sv @@
// Shared types and constants for the sparse matrix-vector accumulator.
// Used by csc_sparse_matvec_accumulator_unit. No dependencies.
`timescale 1ns / 1ps

package csm_pkg;

  // Row store geometry.
  localparam int ROWS   = 4096;
  localparam int ADDR_W = $clog2(ROWS);

  // Field widths.
  localparam int FUNC_W = 2;
  localparam int ROW_W  = 12;
  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int FRAC_W = 16;
  localparam int SUM_W  = 48;

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_ACC      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ_CLR = 2'd2;

  // Saturation bounds of a row sum.
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // One row store entry: sticky clip flag and the running sum.
  typedef struct packed {
    logic                    sat;
    logic signed [SUM_W-1:0] sum;
  } entry_t;

  // Item in the multiply stage.
  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [ROW_W-1:0]         row;
    logic                     rng;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] x_value;
  } mul_stage_t;

  // Item in the accumulate and write-back stage.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ROW_W-1:0]  row;
    logic              rng;
  } acc_stage_t;

endpackage

@@ hw/rtl/csc_sparse_matvec_accumulator_unit.sv @@
// Scatter-accumulate core of a compressed-sparse-column matrix-vector product.
// Holds the per-row sum store and the read, multiply, accumulate pipeline.
// Depends on csm_pkg.
//
//   port group   direction   flow control       payload
//   in_*         input       in_valid/in_stall  func, row, value, x_value
//   out_*        output      out_valid/out_stall row_out, sum_value, saturated
//
// An item is registered into the multiply stage, then the accumulate stage and,
// if it yields a result, the output register. One item per cycle is sustained
// while no result waits under out_stall and no sweep runs; the store read and
// the 32x32 multiply share the multiply stage, the 48-bit add owns the accumulate
// stage, and repeated rows forward from the two most recent writes. After reset
// the store is swept to zero, one entry per cycle, and in_stall stays high during
// the sweep. The pipeline holds as a whole while a result waits under out_stall.
`timescale 1ns / 1ps

module csc_sparse_matvec_accumulator_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [csm_pkg::FUNC_W-1:0]       in_func,
  input  logic [csm_pkg::ROW_W-1:0]        in_row,
  input  logic signed [csm_pkg::DATA_W-1:0] in_value,
  input  logic signed [csm_pkg::DATA_W-1:0] in_x_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [csm_pkg::ROW_W-1:0]        out_row_out,
  output logic signed [csm_pkg::SUM_W-1:0] out_sum_value,
  output logic                             out_saturated
);

  localparam int ADDR_W = csm_pkg::ADDR_W;
  localparam int SUM_W  = csm_pkg::SUM_W;

  // Row store.
  csm_pkg::entry_t mem [csm_pkg::ROWS];
  csm_pkg::entry_t rd_data_r;

  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic en;
  logic accept;

  // Multiply stage.
  logic                 s1_vld_r;
  csm_pkg::mul_stage_t  s1_r;
  logic [ADDR_W-1:0]    s1_addr;
  logic signed [csm_pkg::PROD_W-1:0] prod_full;

  // Accumulate stage.
  logic                          s2_vld_r;
  csm_pkg::acc_stage_t           s2_r;
  logic [ADDR_W-1:0]             s2_addr;
  logic signed [SUM_W-1:0]       s2_prod_r;
  csm_pkg::entry_t               s2_old_r;
  csm_pkg::entry_t               s2_old_nxt;
  logic signed [SUM_W:0]         sum_full;
  logic                          sat_hi;
  logic                          sat_lo;
  csm_pkg::entry_t               acc_entry;

  // Store write port.
  logic              pipe_wr;
  csm_pkg::entry_t   pipe_wr_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  csm_pkg::entry_t   wr_data;

  // Most recent pipeline write, for the read issued at the same edge.
  logic              wb_vld_r;
  logic [ADDR_W-1:0] wb_addr_r;
  csm_pkg::entry_t   wb_data_r;

  // Output register.
  logic                    out_valid_r;
  logic [csm_pkg::ROW_W-1:0] out_row_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic                    out_sat_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = clearing_r || !en;
  assign accept   = in_valid && !in_stall;

  assign s1_addr = ADDR_W'(s1_r.row);
  assign s2_addr = ADDR_W'(s2_r.row);

  // Clearing sweep after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(csm_pkg::ROWS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Accumulate stage arithmetic.
  always_comb begin
    sum_full = {s2_old_r.sum[SUM_W-1], s2_old_r.sum} + {s2_prod_r[SUM_W-1], s2_prod_r};
    sat_hi   = !sum_full[SUM_W] && sum_full[SUM_W-1];
    sat_lo   = sum_full[SUM_W] && !sum_full[SUM_W-1];
    acc_entry.sat = s2_old_r.sat || sat_hi || sat_lo;
    if (sat_hi) begin
      acc_entry.sum = csm_pkg::SUM_MAX;
    end else if (sat_lo) begin
      acc_entry.sum = csm_pkg::SUM_MIN;
    end else begin
      acc_entry.sum = sum_full[SUM_W-1:0];
    end
  end

  // Pipeline write-back: accumulate writes the new sum, read-and-clear writes zero.
  always_comb begin
    pipe_wr      = 1'b0;
    pipe_wr_data = acc_entry;
    if (en && s2_vld_r && s2_r.rng) begin
      unique case (s2_r.func)
        csm_pkg::FUNC_ACC: begin
          pipe_wr = 1'b1;
        end
        csm_pkg::FUNC_READ_CLR: begin
          pipe_wr      = 1'b1;
          pipe_wr_data = '0;
        end
        default: begin
          pipe_wr = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (clearing_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else begin
      wr_en   = pipe_wr;
      wr_addr = s2_addr;
      wr_data = pipe_wr_data;
    end
  end

  // Store read data for the multiply-stage item, newest write first.
  always_comb begin
    if (pipe_wr && s2_addr == s1_addr) begin
      s2_old_nxt = pipe_wr_data;
    end else if (wb_vld_r && wb_addr_r == s1_addr) begin
      s2_old_nxt = wb_data_r;
    end else begin
      s2_old_nxt = rd_data_r;
    end
  end

  assign prod_full = s1_r.value * s1_r.x_value;

  // Synchronous memory, read before write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_data_r <= mem[ADDR_W'(in_row)];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      wb_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_vld_r    <= accept;
      s2_vld_r    <= s1_vld_r;
      wb_vld_r    <= pipe_wr;
      out_valid_r <= s2_vld_r && (s2_r.func == csm_pkg::FUNC_READ ||
                                  s2_r.func == csm_pkg::FUNC_READ_CLR);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.func    <= in_func;
      s1_r.row     <= in_row;
      s1_r.rng     <= 32'(in_row) < csm_pkg::ROWS;
      s1_r.value   <= in_value;
      s1_r.x_value <= in_x_value;
      s2_r.func    <= s1_r.func;
      s2_r.row     <= s1_r.row;
      s2_r.rng     <= s1_r.rng;
      // Dropping the low fraction bits floors the Q32.32 product to Q32.16.
      s2_prod_r    <= prod_full[csm_pkg::FRAC_W +: SUM_W];
      s2_old_r     <= s2_old_nxt;
      wb_addr_r    <= s2_addr;
      wb_data_r    <= pipe_wr_data;
      out_row_r    <= s2_r.row;
      out_sum_r    <= s2_r.rng ? s2_old_r.sum : '0;
      out_sat_r    <= s2_r.rng && s2_old_r.sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_out   = out_row_r;
  assign out_sum_value = out_sum_r;
  assign out_saturated = out_sat_r;

  // The sweep never overlaps pipeline traffic.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> (!accept && !s1_vld_r && !s2_vld_r))
    else $error("item in flight during store clearing");

  // A held pipeline must not write the store.
  a_no_write_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && !clearing_r) |-> !wr_en)
    else $error("store written while pipeline held");

  // A read-and-clear leaves a zero entry behind.
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s2_vld_r && s2_r.rng && s2_r.func == csm_pkg::FUNC_READ_CLR)
    |=> (wb_vld_r && wb_data_r == '0))
    else $error("read-and-clear did not write zero");

  // A clipped accumulate sets the sticky flag in the written entry.
  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_wr && s2_r.func == csm_pkg::FUNC_ACC && (sat_hi || sat_lo))
    |=> (wb_vld_r && wb_data_r.sat))
    else $error("saturation flag lost on clipped sum");

  // A result only follows a read item in the accumulate stage.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !(s2_vld_r && (s2_r.func == csm_pkg::FUNC_READ ||
                         s2_r.func == csm_pkg::FUNC_READ_CLR))) |=> !out_valid_r)
    else $error("result without a read item");

endmodule
